// ===== rtl/bmpf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the border-mode pixel fetch unit.
package bmpf_pkg;

    // Fixed field widths
    localparam int COORD_W = 10;   // signed coordinate width
    localparam int DIM_W   = 9;    // image dimension register width
    localparam int CHAN_W  = 8;    // one color channel
    localparam int PIX_W   = 3 * CHAN_W;
    localparam int RULE_W  = 2;

    // Configuration register indexes
    localparam logic [1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IDX_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_IDX_RULE   = 2'd2;

    // Operation codes
    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // Read border rules
    typedef enum logic [RULE_W-1:0] {
        RULE_CLAMP  = 2'd0,
        RULE_BLACK  = 2'd1,
        RULE_WRAP   = 2'd2,
        RULE_MIRROR = 2'd3
    } border_rule_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic div_step;
        logic resolve;
        logic addr_calc;
        logic mem_access;
        logic load;
    } bmpf_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic wrap_read;
    } bmpf_status_t;

endpackage

// ===== rtl/bmpf_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the border-mode pixel fetch unit.
module bmpf_ctrl import bmpf_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  logic         m_ready,
    input  bmpf_status_t status,
    output bmpf_cmd_t    cmd
);

    localparam int CNT_W = $clog2(COORD_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_RESOLVE,
        ST_ADDR,
        ST_MEM,
        ST_LOAD
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;

    always_comb begin
        cmd          = '0;
        s_ready      = 1'b0;
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    cnt_next    = '0;
                    state_next  = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                // only wrap reads need the full remainder
                if (!status.wrap_read || cnt_reg == CNT_W'(COORD_W - 1)) begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE: begin
                cmd.resolve = 1'b1;
                state_next  = ST_ADDR;
            end
            ST_ADDR: begin
                cmd.addr_calc = 1'b1;
                state_next    = ST_MEM;
            end
            ST_MEM: begin
                cmd.mem_access = 1'b1;
                state_next     = ST_LOAD;
            end
            ST_LOAD: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/bmpf_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the border-mode pixel fetch unit: coordinate resolve, address and frame store.
module bmpf_datapath import bmpf_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                      aclk,
    input  bmpf_cmd_t                 cmd,
    output bmpf_status_t              status,
    input  logic [DIM_W-1:0]          cfg_width,
    input  logic [DIM_W-1:0]          cfg_height,
    input  logic [RULE_W-1:0]         cfg_rule,
    input  logic                      s_mode,
    input  logic signed [COORD_W-1:0] s_x_coord,
    input  logic signed [COORD_W-1:0] s_y_coord,
    input  logic [CHAN_W-1:0]         s_in_red,
    input  logic [CHAN_W-1:0]         s_in_green,
    input  logic [CHAN_W-1:0]         s_in_blue,
    output logic [CHAN_W-1:0]         m_out_red,
    output logic [CHAN_W-1:0]         m_out_green,
    output logic [CHAN_W-1:0]         m_out_blue,
    output logic                      m_in_bounds,
    output logic                      m_write_rejected
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PROD_W = 2 * DIM_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int WIDE_W = COORD_W + 2;

    function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] r, int maxv);
        if (r == '0) begin
            return DIM_W'(1);
        end
        if (int'(r) > maxv) begin
            return DIM_W'(maxv);
        end
        return r;
    endfunction

    // One restoring remainder step: shift in the next dividend bit, subtract if it fits.
    function automatic logic [COORD_W-1:0] rem_step(logic [COORD_W-1:0] rem, logic bit_in,
                                                    logic [DIM_W-1:0] n);
        logic [COORD_W:0] t;
        t = {rem, bit_in};
        if (t >= (COORD_W+1)'(n)) begin
            t = t - (COORD_W+1)'(n);
        end
        return t[COORD_W-1:0];
    endfunction

    function automatic logic [DIM_W-1:0] clamp_coord(logic signed [WIDE_W-1:0] c,
                                                     logic [DIM_W-1:0] n);
        if (c < 0) begin
            return '0;
        end
        if (c >= $signed(WIDE_W'(n))) begin
            return n - 1'b1;
        end
        return c[DIM_W-1:0];
    endfunction

    function automatic logic [DIM_W-1:0] resolve_coord(border_rule_t rule, logic is_write,
                                                       logic signed [COORD_W-1:0] c,
                                                       logic [COORD_W-1:0] rem,
                                                       logic [DIM_W-1:0] n);
        logic signed [WIDE_W-1:0] c_w;
        logic signed [WIDE_W-1:0] n_w;
        logic signed [WIDE_W-1:0] m;
        logic [DIM_W-1:0]         res;
        c_w = WIDE_W'(c);
        n_w = $signed(WIDE_W'(n));
        if (c_w < 0) begin
            m = -c_w;
        end else if (c_w >= n_w) begin
            m = (n_w <<< 1) - c_w - WIDE_W'(2);
        end else begin
            m = c_w;
        end
        unique case (rule)
            RULE_CLAMP:  res = clamp_coord(c_w, n);
            RULE_BLACK:  res = c[DIM_W-1:0];
            RULE_WRAP:   res = (c[COORD_W-1] && rem != '0) ? n - rem[DIM_W-1:0]
                                                           : rem[DIM_W-1:0];
            RULE_MIRROR: res = clamp_coord(m, n);
            default:     res = c[DIM_W-1:0];
        endcase
        // writes only reach the store from inside the image
        return is_write ? c[DIM_W-1:0] : res;
    endfunction

    logic [DIM_W-1:0]          eff_w, eff_h;
    logic                      inb_next;
    logic                      mode_reg;
    logic signed [COORD_W-1:0] x_reg, y_reg;
    logic [PIX_W-1:0]          pix_reg;
    logic [DIM_W-1:0]          w_reg, h_reg;
    border_rule_t              rule_reg;
    logic                      inb_reg;
    logic [COORD_W-1:0]        divx_reg, divy_reg;
    logic [COORD_W-1:0]        remx_reg, remy_reg;
    logic [DIM_W-1:0]          xs_reg, ys_reg;
    logic [PROD_W-1:0]         prod;
    logic [SUM_W-1:0]          sum;
    logic [ADDR_W+SUM_W-1:0]   sum_ext;
    logic [ADDR_W-1:0]         addr_reg;
    logic [PIX_W-1:0]          rd_data_reg;
    logic [PIX_W-1:0]          out_pix;
    logic [PIX_W-1:0]          out_pix_reg;
    logic                      out_inb_reg, out_rej_reg;
    logic [PIX_W-1:0]          mem [DEPTH];

    assign eff_w    = eff_dim(cfg_width, MAX_WIDTH);
    assign eff_h    = eff_dim(cfg_height, MAX_HEIGHT);
    assign inb_next = !s_x_coord[COORD_W-1] && (s_x_coord[DIM_W-1:0] < eff_w) &&
                      !s_y_coord[COORD_W-1] && (s_y_coord[DIM_W-1:0] < eff_h);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg <= s_mode;
            x_reg    <= s_x_coord;
            y_reg    <= s_y_coord;
            pix_reg  <= {s_in_blue, s_in_green, s_in_red};
            w_reg    <= eff_w;
            h_reg    <= eff_h;
            rule_reg <= border_rule_t'(cfg_rule);
            inb_reg  <= inb_next;
            divx_reg <= s_x_coord[COORD_W-1] ? COORD_W'(-s_x_coord) : s_x_coord;
            divy_reg <= s_y_coord[COORD_W-1] ? COORD_W'(-s_y_coord) : s_y_coord;
            remx_reg <= '0;
            remy_reg <= '0;
        end else if (cmd.div_step) begin
            remx_reg <= rem_step(remx_reg, divx_reg[COORD_W-1], w_reg);
            remy_reg <= rem_step(remy_reg, divy_reg[COORD_W-1], h_reg);
            divx_reg <= divx_reg << 1;
            divy_reg <= divy_reg << 1;
        end
    end

    assign status.wrap_read = (mode_reg == MODE_READ) && (rule_reg == RULE_WRAP);

    always_ff @(posedge aclk) begin
        if (cmd.resolve) begin
            xs_reg <= resolve_coord(rule_reg, mode_reg, x_reg, remx_reg, w_reg);
            ys_reg <= resolve_coord(rule_reg, mode_reg, y_reg, remy_reg, h_reg);
        end
    end

    assign prod    = ys_reg * w_reg;
    assign sum     = {1'b0, prod} + {{(SUM_W-DIM_W){1'b0}}, xs_reg};
    assign sum_ext = {{ADDR_W{1'b0}}, sum};

    always_ff @(posedge aclk) begin
        if (cmd.addr_calc) begin
            addr_reg <= sum_ext[ADDR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_access && mode_reg == MODE_WRITE && inb_reg) begin
            mem[addr_reg] <= pix_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_access) begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    assign out_pix = (mode_reg == MODE_WRITE || (rule_reg == RULE_BLACK && !inb_reg)) ?
                     '0 : rd_data_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_pix_reg <= out_pix;
            out_inb_reg <= inb_reg;
            out_rej_reg <= (mode_reg == MODE_WRITE) && !inb_reg;
        end
    end

    assign m_out_red        = out_pix_reg[CHAN_W-1:0];
    assign m_out_green      = out_pix_reg[2*CHAN_W-1:CHAN_W];
    assign m_out_blue       = out_pix_reg[PIX_W-1:2*CHAN_W];
    assign m_in_bounds      = out_inb_reg;
    assign m_write_rejected = out_rej_reg;

endmodule

// ===== rtl/border_mode_pixel_fetch_unit.sv =====
`timescale 1ns / 1ps
// Top level of the border-mode pixel fetch unit: configuration registers, controller and datapath.
//
// A frame store of MAX_WIDTH x MAX_HEIGHT 24-bit RGB pixels, addressed as y * width + x with
// the configured image width. Each item is a read or a write with signed 10-bit coordinates.
// A write inside the image stores the pixel; a write outside is dropped and flagged in
// write_rejected. A read outside the image follows border_rule: clamp to the edge, constant
// black, wrap by modulo, or mirror without repeating the edge (clamped if still outside).
// Every result reports whether the raw coordinate was inside the image. Width or height of
// zero acts as 1, values above the maximum saturate. The store has no reset: reading a pixel
// that was never written returns undefined data. One item is processed at a time. A wrap-rule
// read runs the bit-serial remainder steps, one per coordinate bit, for x and y side by side;
// every other item makes one pass through the divide state. Each item then goes through
// coordinate resolve, address multiply-add, one store access and output load. The result
// sits in an output register, so the next item is accepted while it waits; that item then
// holds in its last stage until the waiting result is taken.
// Write the configuration only while the unit is idle.
module border_mode_pixel_fetch_unit import bmpf_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration write port
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [DIM_W-1:0]          cfg_wdata,
    // input item channel
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_mode,
    input  logic signed [COORD_W-1:0] s_x_coord,
    input  logic signed [COORD_W-1:0] s_y_coord,
    input  logic [CHAN_W-1:0]         s_in_red,
    input  logic [CHAN_W-1:0]         s_in_green,
    input  logic [CHAN_W-1:0]         s_in_blue,
    // result item channel
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [CHAN_W-1:0]         m_out_red,
    output logic [CHAN_W-1:0]         m_out_green,
    output logic [CHAN_W-1:0]         m_out_blue,
    output logic                      m_in_bounds,
    output logic                      m_write_rejected
);

    logic [DIM_W-1:0]  img_width_reg;
    logic [DIM_W-1:0]  img_height_reg;
    logic [RULE_W-1:0] border_rule_reg;
    bmpf_cmd_t         cmd;
    bmpf_status_t      status;

    // Configuration registers; drop writes to an index beyond the list.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            img_width_reg   <= DIM_W'(256);
            img_height_reg  <= DIM_W'(256);
            border_rule_reg <= RULE_CLAMP;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_IDX_WIDTH:  img_width_reg   <= cfg_wdata;
                CFG_IDX_HEIGHT: img_height_reg  <= cfg_wdata;
                CFG_IDX_RULE:   border_rule_reg <= cfg_wdata[RULE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sequence one item through divide, resolve, address, store access and output load.
    bmpf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Coordinate arithmetic, frame store and output register.
    bmpf_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .aclk             (aclk),
        .cmd              (cmd),
        .status           (status),
        .cfg_width        (img_width_reg),
        .cfg_height       (img_height_reg),
        .cfg_rule         (border_rule_reg),
        .s_mode           (s_mode),
        .s_x_coord        (s_x_coord),
        .s_y_coord        (s_y_coord),
        .s_in_red         (s_in_red),
        .s_in_green       (s_in_green),
        .s_in_blue        (s_in_blue),
        .m_out_red        (m_out_red),
        .m_out_green      (m_out_green),
        .m_out_blue       (m_out_blue),
        .m_in_bounds      (m_in_bounds),
        .m_write_rejected (m_write_rejected)
    );

endmodule

// ===== bench/tb_border_mode_pixel_fetch_unit.sv =====
`timescale 1ns / 1ps
// Testbench for the border-mode pixel fetch unit: directed, random and back-pressure tests.
module tb_border_mode_pixel_fetch_unit;
    import bmpf_pkg::*;

    localparam int FRAME_W        = 256;
    localparam int FRAME_H        = 256;
    localparam int FRAME_DEPTH    = FRAME_W * FRAME_H;
    localparam int COORD_MIN      = -512;
    localparam int COORD_MAX      = 511;
    localparam int SETTLE_CYCLES  = 20;    // longest item is a wrap read
    localparam int WATCHDOG_LIMIT = 2000;  // covers the long receiver hold plus stalls
    localparam int REPORT_LIMIT   = 10;
    localparam int WRITE_PCT      = 45;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 145;
    localparam int HOLD_CYCLES    = 200;

    // Index past the end of the register list; writes to it must be ignored.
    localparam logic [1:0] CFG_IDX_UNUSED = 2'd3;

    // One expected result, with the item that caused it for the report.
    typedef struct {
        logic              mode;
        int                x;
        int                y;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              in_bounds;
        logic              write_rejected;
    } fetch_result_t;

    bit                        aclk;
    logic                      aresetn;
    logic                      cfg_we;
    logic [1:0]                cfg_index;
    logic [DIM_W-1:0]          cfg_wdata;
    logic                      s_valid;
    logic                      s_ready;
    logic                      s_mode;
    logic signed [COORD_W-1:0] s_x_coord;
    logic signed [COORD_W-1:0] s_y_coord;
    logic [CHAN_W-1:0]         s_in_red;
    logic [CHAN_W-1:0]         s_in_green;
    logic [CHAN_W-1:0]         s_in_blue;
    logic                      m_valid;
    logic                      m_ready;
    logic [CHAN_W-1:0]         m_out_red;
    logic [CHAN_W-1:0]         m_out_green;
    logic [CHAN_W-1:0]         m_out_blue;
    logic                      m_in_bounds;
    logic                      m_write_rejected;

    // Shadow of the frame store and of the configuration.
    logic [PIX_W-1:0] frame_pixels [FRAME_DEPTH];
    bit               pixel_written [FRAME_DEPTH];
    int               written_addrs [$];
    int               geo_w;
    int               geo_h;
    border_rule_t     geo_rule;

    fetch_result_t    expected_pixels [$];

    // Handshake pacing and bookkeeping.
    bit tx_no_idle;
    bit rx_no_idle;
    int rx_stall_left;
    int rx_hold_cycles;
    int idle_cycles;
    int fault_count;
    int reads_sent;
    int reads_outside;
    int writes_sent;
    int writes_dropped;
    int settings_used;

    border_mode_pixel_fetch_unit #(
        .MAX_WIDTH  (FRAME_W),
        .MAX_HEIGHT (FRAME_H)
    ) u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_x_coord        (s_x_coord),
        .s_y_coord        (s_y_coord),
        .s_in_red         (s_in_red),
        .s_in_green       (s_in_green),
        .s_in_blue        (s_in_blue),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_red        (m_out_red),
        .m_out_green      (m_out_green),
        .m_out_blue       (m_out_blue),
        .m_in_bounds      (m_in_bounds),
        .m_write_rejected (m_write_rejected)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Zero acts as 1; anything above the frame size saturates.
    function automatic int effective_dim(input logic [DIM_W-1:0] raw, input int maxv);
        if (raw == '0)
            return 1;
        if (int'(raw) > maxv)
            return maxv;
        return int'(raw);
    endfunction

    // Map one coordinate onto the image under the current border rule.
    function automatic int border_coord(input int c, input int n);
        int m;
        m = c;
        case (geo_rule)
            RULE_WRAP: begin
                m = c % n;
                if (m < 0)
                    m += n;
            end
            RULE_MIRROR: begin
                if (c < 0)
                    m = -c;
                if (c >= n)
                    m = 2 * n - c - 2;
            end
            default: ;
        endcase
        // Clamp rule, and mirror reflections that still land outside.
        if (m < 0)
            m = 0;
        if (m >= n)
            m = n - 1;
        return m;
    endfunction

    // Store address a read touches, or -1 when it reads constant black.
    function automatic int read_addr(input int x, input int y);
        bit in_image;
        in_image = x >= 0 && x < geo_w && y >= 0 && y < geo_h;
        if (geo_rule == RULE_BLACK && !in_image)
            return -1;
        return border_coord(y, geo_h) * geo_w + border_coord(x, geo_w);
    endfunction

    // Apply one accepted item to the shadow store and return its result.
    function automatic fetch_result_t fetch_pixel(
        input logic                      mode,
        input logic signed [COORD_W-1:0] x,
        input logic signed [COORD_W-1:0] y,
        input logic [CHAN_W-1:0]         red,
        input logic [CHAN_W-1:0]         green,
        input logic [CHAN_W-1:0]         blue
    );
        fetch_result_t res;
        int            xi;
        int            yi;
        int            addr;
        xi = x;
        yi = y;
        res.mode           = mode;
        res.x              = xi;
        res.y              = yi;
        res.red            = '0;
        res.green          = '0;
        res.blue           = '0;
        res.in_bounds      = xi >= 0 && xi < geo_w && yi >= 0 && yi < geo_h;
        res.write_rejected = 1'b0;
        if (mode == MODE_WRITE) begin
            writes_sent++;
            if (res.in_bounds) begin
                addr = yi * geo_w + xi;
                frame_pixels[addr] = {blue, green, red};
                if (!pixel_written[addr]) begin
                    pixel_written[addr] = 1'b1;
                    written_addrs.push_back(addr);
                end
            end else begin
                res.write_rejected = 1'b1;
                writes_dropped++;
            end
        end else begin
            reads_sent++;
            if (!res.in_bounds)
                reads_outside++;
            addr = read_addr(xi, yi);
            if (addr >= 0)
                {res.blue, res.green, res.red} = frame_pixels[addr];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one item after a random gap; return at the falling edge after acceptance
    // with valid still high, so a back-to-back item keeps it high.
    task automatic send_item(
        input logic                      mode,
        input logic signed [COORD_W-1:0] x,
        input logic signed [COORD_W-1:0] y,
        input logic [CHAN_W-1:0]         red,
        input logic [CHAN_W-1:0]         green,
        input logic [CHAN_W-1:0]         blue
    );
        int gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_mode     <= mode;
        s_x_coord  <= x;
        s_y_coord  <= y;
        s_in_red   <= red;
        s_in_green <= green;
        s_in_blue  <= blue;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        expected_pixels.push_back(fetch_pixel(mode, x, y, red, green, blue));
        @(negedge aclk);
    endtask

    // Drop valid and hold until every result is back and the unit has settled.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Write all three registers while idle and mirror them in the shadow copy.
    task automatic program_geometry(
        input logic [DIM_W-1:0] width_raw,
        input logic [DIM_W-1:0] height_raw,
        input border_rule_t     rule
    );
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_WIDTH;
        cfg_wdata <= width_raw;
        @(negedge aclk);
        cfg_index <= CFG_IDX_HEIGHT;
        cfg_wdata <= height_raw;
        @(negedge aclk);
        // Upper data bits are don't-care for the rule register; toggle them anyway.
        cfg_index <= CFG_IDX_RULE;
        cfg_wdata <= {(DIM_W - RULE_W)'($urandom), rule};
        @(negedge aclk);
        cfg_we <= 1'b0;
        geo_w    = effective_dim(width_raw, FRAME_W);
        geo_h    = effective_dim(height_raw, FRAME_H);
        geo_rule = rule;
        settings_used++;
    endtask

    // Raw coordinate somewhere near a target: itself, a wrap or mirror alias, a close neighbour, or anywhere.
    function automatic int near_coord(input int t, input int n);
        int c;
        case ($urandom_range(0, 5))
            0:       c = t;
            1:       c = t + n * (int'($urandom_range(0, 6)) - 3);
            2:       c = -t;
            3:       c = 2 * n - 2 - t;
            4:       c = int'($urandom_range(0, 1023)) + COORD_MIN;
            default: c = t + int'($urandom_range(0, 4)) - 2;
        endcase
        if (c < COORD_MIN || c > COORD_MAX)
            c = t;
        return c;
    endfunction

    // Coordinate inside the image, leaning toward the edges.
    function automatic int pick_inside(input int n);
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return n - 1;
            default: return $urandom_range(0, n - 1);
        endcase
    endfunction

    // One random item. Reads only go where the resolved pixel has been written;
    // when no such pixel is at hand, write instead.
    task automatic send_random_item();
        int a;
        int tries;
        int tx;
        int ty;
        int cx;
        int cy;
        int px;
        int py;
        bit found;
        found = 1'b0;
        if ($urandom_range(0, 99) >= WRITE_PCT && written_addrs.size() != 0) begin
            for (tries = 0; tries < 8 && !found; tries++) begin
                a  = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
                tx = a % geo_w;
                ty = a / geo_w;
                found = ty < geo_h;
            end
        end
        if (found) begin
            // Fall back to the target itself, which always resolves to itself.
            px = tx;
            py = ty;
            for (tries = 0; tries < 8; tries++) begin
                cx = near_coord(tx, geo_w);
                cy = near_coord(ty, geo_h);
                a  = read_addr(cx, cy);
                if (a < 0 || pixel_written[a]) begin
                    px = cx;
                    py = cy;
                    break;
                end
            end
            send_item(MODE_READ, COORD_W'(px), COORD_W'(py),
                      CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
        end else begin
            if ($urandom_range(0, 3) == 0) begin
                px = int'($urandom_range(0, 1023)) + COORD_MIN;
                py = int'($urandom_range(0, 1023)) + COORD_MIN;
            end else begin
                px = pick_inside(geo_w);
                py = pick_inside(geo_h);
            end
            send_item(MODE_WRITE, COORD_W'(px), COORD_W'(py),
                      CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // Receiver pacing: a long hold when asked, else the stall drawn per item.
    initial begin
        forever begin
            @(negedge aclk);
            if (rx_hold_cycles > 0) begin
                m_ready <= 1'b0;
                rx_hold_cycles--;
            end else if (rx_stall_left > 0) begin
                m_ready <= 1'b0;
                rx_stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge aclk) begin
        fetch_result_t want;
        if (aresetn && m_valid && m_ready) begin
            rx_stall_left = rx_no_idle ? 0 : $urandom_range(0, 16);
            if (expected_pixels.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("%0t: result with no item outstanding: rgb %02h %02h %02h",
                             $realtime, m_out_red, m_out_green, m_out_blue);
            end else begin
                want = expected_pixels.pop_front();
                if (m_out_red !== want.red || m_out_green !== want.green
                        || m_out_blue !== want.blue || m_in_bounds !== want.in_bounds
                        || m_write_rejected !== want.write_rejected) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT) begin
                        $display("%0t: mode %0b at (%0d,%0d) with %0dx%0d rule %s",
                                 $realtime, want.mode, want.x, want.y, geo_w, geo_h,
                                 geo_rule.name());
                        $display("    expected rgb %02h %02h %02h in_bounds %0b rejected %0b",
                                 want.red, want.green, want.blue, want.in_bounds,
                                 want.write_rejected);
                        $display("    actual   rgb %02h %02h %02h in_bounds %0b rejected %0b",
                                 m_out_red, m_out_green, m_out_blue, m_in_bounds,
                                 m_write_rejected);
                    end
                end
            end
        end
    end

    // Stop a hung run: count cycles with no item moving on either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                     idle_cycles, expected_pixels.size());
            $display("FAIL border_mode_pixel_fetch_unit");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset geometry (full frame, clamp): corner writes, dropped writes at the
    // coordinate extremes, and clamped reads from the far corners of the range.
    task automatic test_reset_geometry();
        send_item(MODE_WRITE, 10'sd0,   10'sd0,   8'hFF, 8'h00, 8'hA5);
        send_item(MODE_WRITE, 10'sd255, 10'sd255, 8'h00, 8'hFF, 8'h5A);
        send_item(MODE_WRITE, 10'sd255, 10'sd0,   8'h12, 8'h34, 8'h56);
        send_item(MODE_WRITE, 10'sd0,   10'sd255, 8'hED, 8'hCB, 8'hA9);
        send_item(MODE_WRITE, 10'sd256, 10'sd0,   8'h11, 8'h22, 8'h33);
        send_item(MODE_WRITE, -10'sd1,  10'sd5,   8'h44, 8'h55, 8'h66);
        send_item(MODE_WRITE, -10'sd512, -10'sd512, 8'hFF, 8'hFF, 8'hFF);
        send_item(MODE_WRITE, 10'sd511, 10'sd511, 8'h00, 8'h00, 8'h00);
        send_item(MODE_READ,  10'sd0,   10'sd0,   8'h00, 8'h00, 8'h00);
        send_item(MODE_READ,  -10'sd512, -10'sd512, 8'hFF, 8'hFF, 8'hFF);
        send_item(MODE_READ,  10'sd511, 10'sd511, 8'h00, 8'h00, 8'h00);
        send_item(MODE_READ,  10'sd511, -10'sd512, 8'h00, 8'h00, 8'h00);
        send_item(MODE_READ,  -10'sd512, 10'sd511, 8'h00, 8'h00, 8'h00);
    endtask

    // Zero and oversized dimensions, mirror reflections that stay outside,
    // wrap and black rules, and a write to the unused register index.
    task automatic test_config_corners();
        // Zero width and height act as a 1x1 image.
        program_geometry(9'd0, 9'd0, RULE_MIRROR);
        send_item(MODE_READ,  10'sd5,  10'sd5,  8'h00, 8'h00, 8'h00);
        send_item(MODE_READ,  -10'sd3, -10'sd3, 8'h00, 8'h00, 8'h00);
        send_item(MODE_WRITE, 10'sd1,  10'sd0,  8'h77, 8'h88, 8'h99);
        send_item(MODE_READ,  10'sd0,  10'sd0,  8'h00, 8'h00, 8'h00);
        // Oversized values saturate back to the full frame.
        program_geometry(9'd511, 9'd300, RULE_WRAP);
        send_item(MODE_READ, -10'sd1,  -10'sd1, 8'h00, 8'h00, 8'h00);
        send_item(MODE_READ, 10'sd256, 10'sd0,  8'h00, 8'h00, 8'h00);
        // Index past the register list: the width must stay at the full frame.
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_UNUSED;
        cfg_wdata <= 9'd1;
        @(negedge aclk);
        cfg_we <= 1'b0;
        send_item(MODE_READ, 10'sd255, 10'sd0, 8'h00, 8'h00, 8'h00);
        program_geometry(9'd256, 9'd256, RULE_BLACK);
        send_item(MODE_READ,  -10'sd1,  10'sd0,   8'h00, 8'h00, 8'h00);
        send_item(MODE_READ,  10'sd255, 10'sd255, 8'h00, 8'h00, 8'h00);
        send_item(MODE_WRITE, 10'sd255, 10'sd255, 8'hC3, 8'h3C, 8'h81);
        send_item(MODE_READ,  10'sd255, 10'sd255, 8'h00, 8'h00, 8'h00);
    endtask

    // Random items over a sweep of image sizes and rules; the first phases pin
    // the size extremes, the rest are mostly small images.
    task automatic test_random_geometries();
        logic [DIM_W-1:0] w_raw;
        logic [DIM_W-1:0] h_raw;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin
                    w_raw = 9'd256;
                    h_raw = 9'd256;
                end
                1: begin
                    w_raw = 9'd0;
                    h_raw = 9'd0;
                end
                2: begin
                    w_raw = 9'd511;
                    h_raw = 9'd1;
                end
                3: begin
                    w_raw = 9'd1;
                    h_raw = 9'd300;
                end
                default: begin
                    if ($urandom_range(0, 4) == 0) begin
                        w_raw = DIM_W'($urandom_range(0, 511));
                        h_raw = DIM_W'($urandom_range(0, 511));
                    end else begin
                        w_raw = DIM_W'($urandom_range(1, 24));
                        h_raw = DIM_W'($urandom_range(1, 24));
                    end
                end
            endcase
            program_geometry(w_raw, h_raw, border_rule_t'(p % 4));
            // Some phases run without gaps on one or both sides.
            tx_no_idle = p == 5 || p == 7;
            rx_no_idle = p == 6 || p == 7;
            repeat (PHASE_ITEMS) send_random_item();
        end
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
    endtask

    // Hold the receiver off while items keep coming so the unit fills and
    // stalls its input, then pause the sender until everything is back.
    task automatic test_backpressure();
        tx_no_idle     = 1'b1;
        rx_hold_cycles = HOLD_CYCLES;
        repeat (24) send_random_item();
        tx_no_idle = 1'b0;
        wait_drained();
        repeat (24) send_random_item();
    endtask

    initial begin
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_IDX_WIDTH;
        cfg_wdata  = '0;
        s_valid    = 1'b0;
        s_mode     = MODE_READ;
        s_x_coord  = '0;
        s_y_coord  = '0;
        s_in_red   = '0;
        s_in_green = '0;
        s_in_blue  = '0;
        m_ready    = 1'b0;
        geo_w      = FRAME_W;
        geo_h      = FRAME_H;
        geo_rule   = RULE_CLAMP;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_geometry();
        test_config_corners();
        test_random_geometries();
        test_backpressure();
        wait_drained();

        $display("Covered %0d reads (%0d outside the image) and %0d writes (%0d dropped)",
                 reads_sent, reads_outside, writes_sent, writes_dropped);
        $display("across %0d size and border rule settings, with stalls on both channels",
                 settings_used);
        if (fault_count == 0) begin
            $display("PASS border_mode_pixel_fetch_unit");
        end else begin
            $display("%0d mismatching results", fault_count);
            $display("FAIL border_mode_pixel_fetch_unit");
        end
        $finish;
    end

endmodule
